@@ rtl/wavetable_voice_adsr_defines.svh @@
`ifndef WAVETABLE_VOICE_ADSR_DEFINES_SVH
`define WAVETABLE_VOICE_ADSR_DEFINES_SVH

// concurrent check on an explicit clock and active-low reset
`define WVA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same check on the block's own clock and reset
`define WVA_ASSERT_CLK(lbl, prop, msg) \
  `WVA_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/wva_pkg.sv @@
package wva_pkg;

  localparam int unsigned DivW = 16;

  localparam logic [2:0] KindSample = 3'd0;
  localparam logic [2:0] KindEnvelope = 3'd1;
  localparam logic [2:0] KindWrite = 3'd2;
  localparam logic [2:0] KindStart = 3'd3;
  localparam logic [2:0] KindStop = 3'd4;

  localparam logic [15:0] PhaseLimit = 16'h8000;
  localparam logic [15:0] AttackNum = 16'hFFFF;
  localparam logic [15:0] StepNum = 16'h7FFF;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  note_slot;
    logic [15:0] note_pitch;
    logic [15:0] note_attack;
    logic [15:0] note_decay;
    logic [15:0] note_sustain;
    logic [15:0] note_release;
  } in_t;

  typedef struct packed {
    logic [7:0] pwm_duty;
    logic       playing;
  } out_t;

  typedef struct packed {
    logic [15:0] pitch;
    logic [15:0] att;
    logic [15:0] dec;
    logic [15:0] sus;
    logic [15:0] rel;
  } song_entry_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StDuty   = 6'b000010,
    StFetch  = 6'b000100,
    StDivAtt = 6'b001000,
    StDivDec = 6'b010000,
    StDivRel = 6'b100000
  } state_e;

  localparam logic [7:0] SineRom [256] = '{
    8'd125, 8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146,
    8'd149, 8'd152, 8'd156, 8'd159, 8'd162, 8'd165, 8'd168, 8'd171,
    8'd174, 8'd176, 8'd179, 8'd182, 8'd185, 8'd188, 8'd191, 8'd193,
    8'd196, 8'd199, 8'd201, 8'd204, 8'd206, 8'd209, 8'd211, 8'd213,
    8'd216, 8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230,
    8'd232, 8'd234, 8'd236, 8'd237, 8'd239, 8'd240, 8'd242, 8'd243,
    8'd245, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd252,
    8'd252, 8'd253, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254,
    8'd254, 8'd253, 8'd252, 8'd252, 8'd251, 8'd250, 8'd249, 8'd248,
    8'd247, 8'd246, 8'd245, 8'd243, 8'd242, 8'd240, 8'd239, 8'd237,
    8'd236, 8'd234, 8'd232, 8'd230, 8'd228, 8'd226, 8'd224, 8'd222,
    8'd220, 8'd218, 8'd216, 8'd213, 8'd211, 8'd209, 8'd206, 8'd204,
    8'd201, 8'd199, 8'd196, 8'd193, 8'd191, 8'd188, 8'd185, 8'd182,
    8'd179, 8'd176, 8'd174, 8'd171, 8'd168, 8'd165, 8'd162, 8'd159,
    8'd156, 8'd152, 8'd149, 8'd146, 8'd143, 8'd140, 8'd137, 8'd134,
    8'd131, 8'd128, 8'd124, 8'd121, 8'd118, 8'd115, 8'd112, 8'd109,
    8'd106, 8'd103, 8'd99,  8'd96,  8'd93,  8'd90,  8'd87,  8'd84,
    8'd81,  8'd79,  8'd76,  8'd73,  8'd70,  8'd67,  8'd64,  8'd62,
    8'd59,  8'd56,  8'd54,  8'd51,  8'd49,  8'd46,  8'd44,  8'd42,
    8'd39,  8'd37,  8'd35,  8'd33,  8'd31,  8'd29,  8'd27,  8'd25,
    8'd23,  8'd21,  8'd19,  8'd18,  8'd16,  8'd15,  8'd13,  8'd12,
    8'd10,  8'd9,   8'd8,   8'd7,   8'd6,   8'd5,   8'd4,   8'd3,
    8'd3,   8'd2,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,
    8'd1,   8'd2,   8'd3,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,
    8'd8,   8'd9,   8'd10,  8'd12,  8'd13,  8'd15,  8'd16,  8'd18,
    8'd19,  8'd21,  8'd23,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,
    8'd35,  8'd37,  8'd39,  8'd42,  8'd44,  8'd46,  8'd49,  8'd51,
    8'd54,  8'd56,  8'd59,  8'd62,  8'd64,  8'd67,  8'd70,  8'd73,
    8'd76,  8'd79,  8'd81,  8'd84,  8'd87,  8'd90,  8'd93,  8'd96,
    8'd99,  8'd103, 8'd106, 8'd109, 8'd112, 8'd115, 8'd118, 8'd121
  };

endpackage

@@ rtl/wva_song_mem.sv @@
module wva_song_mem #(
  parameter int unsigned Depth = 64
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [$clog2(Depth)-1:0]  waddr_i,
  input  wva_pkg::song_entry_t      wdata_i,
  input  logic                      re_i,
  input  logic [$clog2(Depth)-1:0]  raddr_i,
  output wva_pkg::song_entry_t      rdata_o
);
  import wva_pkg::*;

  song_entry_t mem_q [Depth];
  song_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/wva_divider.sv @@
module wva_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wva_pkg::div_req_t req_i,
  output wva_pkg::div_rsp_t rsp_o
);
  import wva_pkg::*;

  localparam int unsigned CntW = $clog2(DivW);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW-1:0] rem_q;
  logic [DivW-1:0] rem_d;
  logic [DivW-1:0] quo_q;
  logic [DivW-1:0] div_q;
  logic [DivW:0]   shifted;
  logic            qbit;

  always_comb begin
    shifted = {rem_q, quo_q[DivW-1]};
    qbit    = shifted >= {1'b0, div_q};
    rem_d   = qbit ? DivW'(shifted - {1'b0, div_q}) : shifted[DivW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DivW-2:0], qbit};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ rtl/wavetable_voice_adsr.sv @@
// One-voice sine generator with an attack/decay/sustain/release envelope that
// plays a song of notes held in an on-chip table. Stop, start, note writes,
// idle ticks and envelope ticks inside a note are handled in the idle state; a
// sample tick while playing does the phase add, then the sine lookup and
// scaling in the duty state; an envelope tick that ends a note does one
// song-table read followed by three 16-bit divisions on one shared restoring
// divider that retires one quotient bit per cycle. One transaction is in work
// at a time; the result register lets the next transaction enter as the last
// result is taken. Configuration writes take effect at once.
module wavetable_voice_adsr #(
  parameter int unsigned SONG_DEPTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  wva_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output wva_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i
);
  import wva_pkg::*;

  localparam int unsigned PosW = $clog2(SONG_DEPTH);

  state_e      st_q;
  logic        out_valid_q;
  logic        play_q;
  logic [7:0]  duty_q;
  logic [15:0] end_marker_q;
  logic [15:0] phase_q;
  logic [15:0] pitch_q;
  logic [15:0] level_q;
  logic [15:0] slice_q;
  logic [15:0] attack_inc_q;
  logic [15:0] decay_dec_q;
  logic [15:0] release_dec_q;
  logic [15:0] attack_end_q;
  logic [15:0] decay_end_q;
  logic [15:0] sustain_end_q;
  logic [15:0] release_end_q;
  logic [PosW-1:0] pos_q;
  logic [PosW-1:0] pos_d;
  song_entry_t ent_q;

  logic        in_acc;
  logic        mem_we;
  logic        mem_re;
  song_entry_t mem_wdata;
  song_entry_t mem_rdata;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic [15:0] phase_sum;
  logic [15:0] phase_d;
  logic [15:0] duty_prod;
  logic        in_note;
  logic        in_attack;
  logic        in_decay;
  logic        in_release;
  logic [15:0] level_ad;
  logic [15:0] level_d;

  assign in_ready_o  = (st_q == StIdle) && (!out_valid_q || out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o.pwm_duty = duty_q;
  assign out_data_o.playing  = play_q;

  always_comb begin
    phase_sum = phase_q + pitch_q;
    phase_d   = (phase_sum > PhaseLimit) ? 16'd0 : phase_sum;
    duty_prod = 16'(SineRom[phase_q[14:7]]) * 16'(level_q[15:8]);

    in_note    = slice_q < release_end_q;
    in_attack  = slice_q < attack_end_q;
    in_decay   = (slice_q > attack_end_q) && (slice_q < decay_end_q);
    in_release = slice_q > sustain_end_q;
    if (in_attack) begin
      level_ad = level_q + attack_inc_q;
    end else if (in_decay) begin
      level_ad = level_q - decay_dec_q;
    end else begin
      level_ad = level_q;
    end
    level_d = in_release ? level_ad - release_dec_q : level_ad;

    pos_d = (pos_q == PosW'(SONG_DEPTH - 1)) ? '0 : pos_q + PosW'(1);
  end

  always_comb begin
    mem_we          = in_acc && (in_data_i.kind == KindWrite)
                      && (32'(in_data_i.note_slot) < 32'(SONG_DEPTH));
    mem_wdata.pitch = in_data_i.note_pitch;
    mem_wdata.att   = in_data_i.note_attack;
    mem_wdata.dec   = in_data_i.note_decay;
    mem_wdata.sus   = in_data_i.note_sustain;
    mem_wdata.rel   = in_data_i.note_release;
    mem_re          = in_acc && (in_data_i.kind == KindEnvelope) && play_q && !in_note;
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = StepNum;
    div_req.divisor  = ent_q.dec;
    case (st_q)
      StFetch: begin
        div_req.start    = 1'b1;
        div_req.dividend = AttackNum;
        div_req.divisor  = mem_rdata.att;
      end
      StDivAtt: begin
        div_req.start   = div_rsp.done;
        div_req.divisor = ent_q.dec;
      end
      StDivDec: begin
        div_req.start   = div_rsp.done;
        div_req.divisor = ent_q.rel;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  wva_song_mem #(
    .Depth (SONG_DEPTH)
  ) u_song_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (PosW'(in_data_i.note_slot)),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (pos_q),
    .rdata_o (mem_rdata)
  );

  wva_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (st_q == StFetch) begin
      ent_q <= mem_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= StIdle;
      out_valid_q   <= 1'b0;
      play_q        <= 1'b0;
      duty_q        <= '0;
      end_marker_q  <= '0;
      phase_q       <= '0;
      pitch_q       <= '0;
      level_q       <= '0;
      slice_q       <= '0;
      attack_inc_q  <= '0;
      decay_dec_q   <= '0;
      release_dec_q <= '0;
      attack_end_q  <= '0;
      decay_end_q   <= '0;
      sustain_end_q <= '0;
      release_end_q <= '0;
      pos_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        end_marker_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        StIdle: begin
          if (in_acc) begin
            out_valid_q <= 1'b1;
            case (in_data_i.kind)
              KindSample: begin
                if (play_q) begin
                  phase_q     <= phase_d;
                  out_valid_q <= 1'b0;
                  st_q        <= StDuty;
                end
              end
              KindEnvelope: begin
                if (play_q && in_note) begin
                  level_q <= level_d;
                  slice_q <= slice_q + 16'd1;
                end else if (play_q) begin
                  out_valid_q <= 1'b0;
                  st_q        <= StFetch;
                end
              end
              KindStart: begin
                pos_q  <= '0;
                play_q <= 1'b1;
              end
              KindStop: begin
                play_q <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        StDuty: begin
          duty_q      <= duty_prod[15:8];
          out_valid_q <= 1'b1;
          st_q        <= StIdle;
        end
        StFetch: begin
          pos_q        <= pos_d;
          slice_q      <= '0;
          level_q      <= '0;
          pitch_q      <= mem_rdata.pitch;
          attack_end_q <= mem_rdata.att;
          if (mem_rdata.pitch == end_marker_q) begin
            play_q <= 1'b0;
          end
          st_q <= StDivAtt;
        end
        StDivAtt: begin
          if (div_rsp.done) begin
            attack_inc_q <= (ent_q.att == '0) ? AttackNum : div_rsp.quotient;
            decay_end_q  <= attack_end_q + ent_q.dec;
            st_q         <= StDivDec;
          end
        end
        StDivDec: begin
          if (div_rsp.done) begin
            decay_dec_q   <= (ent_q.dec == '0) ? StepNum : div_rsp.quotient;
            sustain_end_q <= decay_end_q + ent_q.sus;
            st_q          <= StDivRel;
          end
        end
        StDivRel: begin
          if (div_rsp.done) begin
            release_dec_q <= (ent_q.rel == '0) ? StepNum : div_rsp.quotient;
            release_end_q <= sustain_end_q + ent_q.rel;
            out_valid_q   <= 1'b1;
            st_q          <= StIdle;
          end
        end
        default: begin
          st_q <= StIdle;
        end
      endcase
    end
  end

endmodule

@@ rtl/wva_checker.sv @@
`include "wavetable_voice_adsr_defines.svh"

module wva_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input wva_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input wva_pkg::out_t out_data_o
);
  import wva_pkg::*;

  `WVA_ASSERT_CLK(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result changed while stalled")
  `WVA_ASSERT_CLK(a_one_pending, out_valid_o && !out_ready_i |-> !in_ready_o, "input taken over a pending result")
  `WVA_ASSERT_CLK(a_stop, in_valid_i && in_ready_o && (in_data_i.kind == KindStop) |=> out_valid_o && !out_data_o.playing, "stop not reported")
  `WVA_ASSERT_CLK(a_start, in_valid_i && in_ready_o && (in_data_i.kind == KindStart) |=> out_valid_o && out_data_o.playing, "start not reported")

endmodule

bind wavetable_voice_adsr wva_checker u_wva_checker (.*);
